// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Concurrent assertion, clocked on posedge clk, disabled during reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`endif

// ===== rtl/cst_pkg.sv =====
// Package for the character stream tokenizer: types, constants, char classes.
// No dependencies.
package cst_pkg;
    localparam int TableEntries = 64;
    localparam int MaxIdLen     = 16;
    localparam int IdxW         = $clog2(TableEntries);
    localparam int CntW         = $clog2(TableEntries + 1);
    localparam int LenW         = $clog2(MaxIdLen + 1);
    localparam int PosW         = $clog2(MaxIdLen);
    localparam int StoreDepth   = TableEntries * MaxIdLen;
    localparam int StoreAw      = $clog2(StoreDepth);

    localparam logic [2:0] KIND_NUMBER = 3'd0;
    localparam logic [2:0] KIND_IDENT  = 3'd1;
    localparam logic [2:0] KIND_TRUE   = 3'd2;
    localparam logic [2:0] KIND_FALSE  = 3'd3;
    localparam logic [2:0] KIND_OP     = 3'd4;

    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_SLASH = 8'd47;
    localparam logic [7:0] CH_STAR  = 8'd42;
    localparam logic [7:0] CH_NL    = 8'd10;

    typedef enum logic [6:0] {
        MODE_IDLE  = 7'b0000001,
        MODE_NUM   = 7'b0000010,
        MODE_NAME  = 7'b0000100,
        MODE_SLASH = 7'b0001000,
        MODE_LINE  = 7'b0010000,
        MODE_BLOCK = 7'b0100000,
        MODE_STAR  = 7'b1000000
    } mode_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       end_of_input;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] number_value;
        logic [5:0]  entry_index;
        logic        is_new;
        logic [7:0]  op_char;
        logic        name_truncated;
        logic        table_full;
        logic [15:0] line_number;
        logic        last;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic       search_init; // start table search at entry 0
        logic       search_step; // advance compare
        logic       insert_step; // write one byte of new name
        logic       insert_done; // finalize insertion
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic found;
        logic miss;      // searched all entries
        logic ins_last;  // last byte being written
        logic can_insert;
    } dp_sts_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction
    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction
    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction
endpackage

// ===== rtl/char_stream_tokenizer.sv =====
// Top level of the character stream tokenizer.
// Depends on cst_pkg, cst_ctrl and cst_symtab.
//
//  channel | handshake            | payload
//  in      | in_valid / in_ready  | in_data  (cst_pkg::in_item_t)
//  out     | out_valid / out_ready| out_data (cst_pkg::out_item_t)
//
// Most characters are handled in the accept state. A name end adds the table
// search (a read, then a compare, per entry and per compared byte), a write of
// a new name byte by byte into the store memory (one write port), and emit.
// Tokens leave through a single output register; a second token waits for it.
// Reset is asynchronous; the table holds true and false after it.
module char_stream_tokenizer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cst_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output cst_pkg::out_item_t out_data
);
    import cst_pkg::*;

    dp_cmd_t         cmd;
    dp_sts_t         sts;
    logic            name_clear, name_push, name_cut;
    logic [7:0]      name_char;
    logic [IdxW-1:0] hit_index, new_index;

    cst_ctrl u_ctrl (
        .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
        .out_data, .cmd, .name_clear, .name_push, .name_char, .sts,
        .hit_index, .new_index, .name_cut
    );

    cst_symtab u_symtab (
        .clk, .rst_n, .cmd, .name_clear, .name_push, .name_char, .sts,
        .hit_index, .new_index, .name_cut
    );
endmodule

// ===== rtl/cst_symtab.sv =====
// Symbol table datapath: name buffer, entry store, sequential search and insert.
// Depends on cst_pkg.
module cst_symtab (
    input  logic                 clk,
    input  logic                 rst_n,
    input  cst_pkg::dp_cmd_t     cmd,
    input  logic                 name_clear,
    input  logic                 name_push,
    input  logic [7:0]           name_char,
    output cst_pkg::dp_sts_t     sts,
    output logic [cst_pkg::IdxW-1:0] hit_index,
    output logic [cst_pkg::IdxW-1:0] new_index,
    output logic                 name_cut
);
    import cst_pkg::*;

    logic [7:0]      buf_reg [MaxIdLen];
    logic [LenW-1:0] len_reg, len_next;
    logic            cut_reg, cut_next;
    logic [LenW-1:0] elen_reg [TableEntries];
    logic [LenW-1:0] elen_rd_reg;
    logic [CntW-1:0] count_reg;
    logic [CntW-1:0] ent_reg;
    logic [LenW-1:0] pos_reg;
    logic            mism_reg;
    logic            ph_reg;     // 0: issue read, 1: compare
    logic [7:0]      mem [StoreDepth];
    logic [7:0]      rd_reg;
    logic [StoreAw-1:0] rd_addr, wr_addr;
    logic [PosW-1:0] pos_idx;
    logic [IdxW-1:0] ent_idx;
    logic            len_eq, cmp_end;

    assign pos_idx = pos_reg[PosW-1:0];
    assign ent_idx = ent_reg[IdxW-1:0];
    assign rd_addr = StoreAw'(ent_idx) * StoreAw'(MaxIdLen) + StoreAw'(pos_idx);
    assign wr_addr = StoreAw'(count_reg[IdxW-1:0]) * StoreAw'(MaxIdLen) + StoreAw'(pos_idx);

    // name buffer
    always_comb
    begin
        len_next = len_reg;
        cut_next = cut_reg;
        if (name_clear)
        begin
            len_next = '0;
            cut_next = 1'b0;
        end
        if (name_push)
        begin
            if (len_next < LenW'(MaxIdLen))
                len_next = len_next + 1'b1;
            else
                cut_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (name_push)
        begin
            if (name_clear)
                buf_reg[0] <= name_char;
            else if (len_reg < LenW'(MaxIdLen))
                buf_reg[len_reg[PosW-1:0]] <= name_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= '0;
            cut_reg <= 1'b0;
        end
        else
        begin
            len_reg <= len_next;
            cut_reg <= cut_next;
        end
    end
    assign name_cut = cut_reg;

    // store memory; preloaded words are served from constants
    always_ff @(posedge clk)
    begin
        if (cmd.insert_step)
            mem[wr_addr] <= buf_reg[pos_idx];
        rd_reg <= mem[rd_addr];
    end

    logic [7:0] const_byte;
    always_comb
    begin
        const_byte = 8'd0;
        if (ent_idx == IdxW'(0))
        begin
            case (pos_idx)
                PosW'(0): const_byte = 8'd116;
                PosW'(1): const_byte = 8'd114;
                PosW'(2): const_byte = 8'd117;
                PosW'(3): const_byte = 8'd101;
                default:  const_byte = 8'd0;
            endcase
        end
        else
        begin
            case (pos_idx)
                PosW'(0): const_byte = 8'd102;
                PosW'(1): const_byte = 8'd97;
                PosW'(2): const_byte = 8'd108;
                PosW'(3): const_byte = 8'd115;
                PosW'(4): const_byte = 8'd101;
                default:  const_byte = 8'd0;
            endcase
        end
    end
    logic [7:0] const_reg;
    logic       pre_reg;
    always_ff @(posedge clk)
    begin
        const_reg <= const_byte;
        pre_reg   <= (ent_reg < CntW'(2));
    end
    logic [7:0] store_byte;
    assign store_byte = pre_reg ? const_reg : rd_reg;

    logic [LenW-1:0] cur_elen;
    assign cur_elen = (ent_reg == CntW'(0)) ? LenW'(4) :
                      (ent_reg == CntW'(1)) ? LenW'(5) : elen_rd_reg;
    assign len_eq   = (cur_elen == len_reg);
    assign cmp_end  = (pos_reg == len_reg);

    // each search step issues a read, then decides on length and byte (ph_reg)
    logic at_end;
    assign at_end = (ent_reg >= count_reg);
    assign sts.miss  = cmd.search_step && at_end;
    assign sts.found = cmd.search_step && !at_end && ph_reg && len_eq && cmp_end && !mism_reg;
    assign sts.can_insert = (count_reg < CntW'(TableEntries));
    assign sts.ins_last = (pos_reg + 1'b1 >= len_reg);
    assign hit_index = ent_idx;
    assign new_index = count_reg[IdxW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= CntW'(2);
            ent_reg   <= '0;
            pos_reg   <= '0;
            mism_reg  <= 1'b0;
            ph_reg    <= 1'b0;
        end
        else if (cmd.search_init)
        begin
            ent_reg  <= '0;
            pos_reg  <= '0;
            mism_reg <= 1'b0;
            ph_reg   <= 1'b0;
        end
        else if (cmd.search_step && !at_end)
        begin
            if (!ph_reg)
                ph_reg <= 1'b1;
            else if (!len_eq || mism_reg || cmp_end)
            begin
                if (!(len_eq && cmp_end && !mism_reg))
                begin
                    ent_reg  <= ent_reg + 1'b1;
                    pos_reg  <= '0;
                    mism_reg <= 1'b0;
                    ph_reg   <= 1'b0;
                end
            end
            else
            begin
                ph_reg <= 1'b0;
                if (store_byte != buf_reg[pos_idx])
                    mism_reg <= 1'b1;
                else
                    pos_reg <= pos_reg + 1'b1;
            end
        end
        else if (cmd.insert_step)
        begin
            if (sts.ins_last)
                pos_reg <= '0;
            else
                pos_reg <= pos_reg + 1'b1;
        end
        else if (cmd.insert_done)
        begin
            count_reg <= count_reg + 1'b1;
            pos_reg   <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.insert_done)
            elen_reg[count_reg[IdxW-1:0]] <= len_reg;
        elen_rd_reg <= elen_reg[ent_idx];
    end
endmodule

// ===== rtl/cst_ctrl.sv =====
// Tokenizer controller: scan mode machine, number accumulator, line count, output.
// Depends on cst_pkg and drives cst_symtab.
module cst_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  cst_pkg::in_item_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output cst_pkg::out_item_t   out_data,
    output cst_pkg::dp_cmd_t     cmd,
    output logic                 name_clear,
    output logic                 name_push,
    output logic [7:0]           name_char,
    input  cst_pkg::dp_sts_t     sts,
    input  logic [cst_pkg::IdxW-1:0] hit_index,
    input  logic [cst_pkg::IdxW-1:0] new_index,
    input  logic                 name_cut
);
    import cst_pkg::*;

    typedef enum logic [4:0] {
        ST_ACCEPT = 5'b00001,
        ST_SEARCH = 5'b00010,
        ST_INSERT = 5'b00100,
        ST_EMIT   = 5'b01000,
        ST_SECOND = 5'b10000
    } st_t;

    st_t         st_reg, st_next;
    mode_t       mode_reg, mode_next;
    logic [31:0] acc_reg, acc_next;
    logic [15:0] line_reg, line_next;
    in_item_t    item_reg;
    logic        item_en;
    out_item_t   ob_reg, ob_next;
    logic        ov_reg, ov_next;
    out_item_t   tok_reg, tok_next;   // pending first token
    logic        tok_en;
    logic        two_reg, two_next;   // second token exists
    out_item_t   sec_reg, sec_next;

    logic [7:0] c;
    logic       eoi, accept;
    assign accept = in_valid && in_ready;
    // held character once the item has been taken
    assign c   = (st_reg == ST_ACCEPT) ? in_data.ch : item_reg.ch;
    assign eoi = in_data.end_of_input;

    // output slot free after this edge
    logic slot_free;
    assign slot_free = !ov_reg || out_ready;
    assign in_ready  = (st_reg == ST_ACCEPT) && slot_free;

    function automatic out_item_t mk(input logic [2:0] k, input logic [31:0] n,
                                     input logic [7:0] op, input logic [15:0] ln,
                                     input logic lst);
        out_item_t r;
        r = '0;
        r.kind = k;
        r.number_value = n;
        r.op_char = op;
        r.line_number = ln;
        r.last = lst;
        return r;
    endfunction

    logic [15:0] line_inc;
    assign line_inc = (line_reg == 16'hFFFF) ? line_reg : line_reg + 16'd1;
    logic [31:0] acc_x10;
    assign acc_x10 = {acc_reg[28:0], 3'b000} + {acc_reg[30:0], 1'b0};

    // idle handling: returns op token flag, next mode, line, acc, name start
    logic       id_op, id_name;
    mode_t      id_mode;
    logic [15:0] id_line;
    logic [31:0] id_acc;
    always_comb
    begin
        id_op = 1'b0; id_name = 1'b0; id_mode = MODE_IDLE;
        id_line = line_reg; id_acc = acc_reg;
        if (is_space(c))
        begin
            if (c == CH_NL) id_line = line_inc;
        end
        else if (is_digit(c))
        begin
            id_acc = {24'd0, c - CH_ZERO};
            id_mode = MODE_NUM;
        end
        else if (c == CH_SLASH)
            id_mode = MODE_SLASH;
        else if (is_letter(c))
        begin
            id_name = 1'b1;
            id_mode = MODE_NAME;
        end
        else
            id_op = 1'b1;
    end

    always_comb
    begin
        st_next = st_reg; mode_next = mode_reg; acc_next = acc_reg;
        line_next = line_reg; ob_next = ob_reg; ov_next = ov_reg;
        tok_next = tok_reg; two_next = two_reg; sec_next = sec_reg;
        item_en = 1'b0; tok_en = 1'b0;
        cmd = '0; name_clear = 1'b0; name_push = 1'b0; name_char = c;
        if (ov_reg && out_ready) ov_next = 1'b0;
        case (st_reg)
            ST_ACCEPT:
            begin
                if (accept)
                begin
                    item_en = 1'b1;
                    if (eoi)
                    begin
                        mode_next = MODE_IDLE;
                        acc_next = '0;
                        case (mode_reg)
                            MODE_NUM:
                            begin
                                ob_next = mk(KIND_NUMBER, acc_reg, 8'd0, line_reg, 1'b1);
                                ov_next = 1'b1;
                            end
                            MODE_SLASH:
                            begin
                                ob_next = mk(KIND_OP, 32'd0, CH_SLASH, line_reg, 1'b1);
                                ov_next = 1'b1;
                            end
                            MODE_NAME:
                            begin
                                two_next = 1'b0;
                                cmd.search_init = 1'b1;
                                st_next = ST_SEARCH;
                            end
                            default: ;
                        endcase
                        if (mode_reg != MODE_NAME)
                            name_clear = 1'b1;
                    end
                    else
                    begin
                        case (mode_reg)
                            MODE_NUM:
                            begin
                                if (is_digit(c))
                                    acc_next = acc_x10 + {24'd0, c - CH_ZERO};
                                else
                                begin
                                    mode_next = id_mode; line_next = id_line;
                                    acc_next = id_acc;
                                    name_clear = id_name; name_push = id_name;
                                    ob_next = mk(KIND_NUMBER, acc_reg, 8'd0, line_reg, !id_op);
                                    ov_next = 1'b1;
                                    if (id_op)
                                    begin
                                        sec_next = mk(KIND_OP, 32'd0, c, id_line, 1'b1);
                                        st_next = ST_SECOND;
                                    end
                                end
                            end
                            MODE_NAME:
                            begin
                                if (is_letter(c))
                                    name_push = 1'b1;
                                else
                                begin
                                    // line update deferred: token shows old line
                                    two_next = id_op;
                                    cmd.search_init = 1'b1;
                                    st_next = ST_SEARCH;
                                end
                            end
                            MODE_SLASH:
                            begin
                                if (c == CH_SLASH) mode_next = MODE_LINE;
                                else if (c == CH_STAR) mode_next = MODE_BLOCK;
                                else
                                begin
                                    mode_next = id_mode; line_next = id_line;
                                    acc_next = id_acc;
                                    name_clear = id_name; name_push = id_name;
                                    ob_next = mk(KIND_OP, 32'd0, CH_SLASH, line_reg, !id_op);
                                    ov_next = 1'b1;
                                    if (id_op)
                                    begin
                                        sec_next = mk(KIND_OP, 32'd0, c, id_line, 1'b1);
                                        st_next = ST_SECOND;
                                    end
                                end
                            end
                            MODE_LINE:
                            begin
                                if (c == CH_NL)
                                begin
                                    line_next = line_inc; mode_next = MODE_IDLE;
                                end
                            end
                            MODE_BLOCK:
                            begin
                                if (c == CH_NL) line_next = line_inc;
                                else if (c == CH_STAR) mode_next = MODE_STAR;
                            end
                            MODE_STAR:
                            begin
                                if (c == CH_SLASH) mode_next = MODE_IDLE;
                                else if (c != CH_STAR)
                                begin
                                    if (c == CH_NL) line_next = line_inc;
                                    mode_next = MODE_BLOCK;
                                end
                            end
                            default:
                            begin
                                mode_next = id_mode; line_next = id_line;
                                acc_next = id_acc;
                                name_clear = id_name; name_push = id_name;
                                if (id_op)
                                begin
                                    ob_next = mk(KIND_OP, 32'd0, c, line_reg, 1'b1);
                                    ov_next = 1'b1;
                                end
                            end
                        endcase
                    end
                end
            end
            ST_SEARCH:
            begin
                cmd.search_step = 1'b1;
                if (sts.found)
                begin
                    tok_en = 1'b1;
                    tok_next = mk((hit_index == IdxW'(0)) ? KIND_TRUE :
                                  (hit_index == IdxW'(1)) ? KIND_FALSE : KIND_IDENT,
                                  32'd0, 8'd0, line_reg, 1'b0);
                    tok_next.entry_index = 6'(hit_index);
                    tok_next.name_truncated = name_cut;
                    st_next = ST_EMIT;
                end
                else if (sts.miss)
                begin
                    tok_en = 1'b1;
                    tok_next = mk(KIND_IDENT, 32'd0, 8'd0, line_reg, 1'b0);
                    tok_next.name_truncated = name_cut;
                    if (sts.can_insert)
                    begin
                        tok_next.entry_index = 6'(new_index);
                        tok_next.is_new = 1'b1;
                        st_next = ST_INSERT;
                    end
                    else
                    begin
                        tok_next.table_full = 1'b1;
                        st_next = ST_EMIT;
                    end
                end
            end
            ST_INSERT:
            begin
                cmd.insert_step = 1'b1;
                if (sts.ins_last)
                    st_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (slot_free)
                begin
                    if (tok_reg.is_new) cmd.insert_done = 1'b1;
                    ob_next = tok_reg;
                    ob_next.last = !two_reg;
                    ov_next = 1'b1;
                    mode_next = MODE_IDLE;
                    name_clear = 1'b1;
                    if (item_reg.end_of_input)
                    begin
                        acc_next = '0;
                        st_next = ST_ACCEPT;
                    end
                    else
                    begin
                        mode_next = id_mode; line_next = id_line; acc_next = id_acc;
                        name_push = id_name; name_char = item_reg.ch;
                        if (two_reg)
                        begin
                            sec_next = mk(KIND_OP, 32'd0, item_reg.ch, id_line, 1'b1);
                            st_next = ST_SECOND;
                        end
                        else
                            st_next = ST_ACCEPT;
                    end
                end
            end
            ST_SECOND:
            begin
                if (slot_free)
                begin
                    ob_next = sec_reg;
                    ov_next = 1'b1;
                    st_next = ST_ACCEPT;
                end
            end
            default: st_next = ST_ACCEPT;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (item_en) item_reg <= in_data;
        if (tok_en) tok_reg <= tok_next;
        if (ov_next && !(ov_reg && !out_ready)) ob_reg <= ob_next;
        sec_reg <= sec_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_ACCEPT;
            mode_reg <= MODE_IDLE;
            acc_reg  <= '0;
            line_reg <= 16'd1;
            ov_reg   <= 1'b0;
            two_reg  <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            mode_reg <= mode_next;
            acc_reg  <= acc_next;
            line_reg <= line_next;
            ov_reg   <= ov_next;
            two_reg  <= two_next;
        end
    end

    assign out_valid = ov_reg;
    assign out_data  = ob_reg;
endmodule

// ===== rtl/cst_checker.sv =====
// Port-level checker for the tokenizer, bound to the top level.
// Depends on cst_pkg and assert_macros.svh.
`include "assert_macros.svh"
module cst_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input cst_pkg::in_item_t  in_data,
    input logic               out_valid,
    input logic               out_ready,
    input cst_pkg::out_item_t out_data
);
    import cst_pkg::*;

    `ASSERT_CLK(a_in_hold, clk, rst_n, in_valid && !in_ready |=> in_valid && $stable(in_data), "input changed while waiting")
    `ASSERT_CLK(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data), "output changed while stalled")
    `ASSERT_CLK(a_kind_range, clk, rst_n, out_valid |-> out_data.kind <= KIND_OP, "bad token kind")
    `ASSERT_CLK(a_line_nonzero, clk, rst_n, out_valid |-> out_data.line_number != 16'd0, "line number zero")
    `ASSERT_CLK(a_op_fields, clk, rst_n, out_valid && out_data.kind == KIND_OP |-> out_data.number_value == 32'd0 && !out_data.is_new, "operator token carries number")
endmodule

bind char_stream_tokenizer cst_checker u_cst_checker (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
);

// ===== tb/sv/tb_token_checker.sv =====
// Token checker for the character stream tokenizer: predicts tokens from
// accepted characters and compares them with the output channel.
// Depends on cst_pkg.
module tb_token_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  cst_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  cst_pkg::out_item_t out_data,
    output int                 fail_count,
    output int                 pending_tokens
);
    timeunit 1ns;
    timeprecision 1ps;
    import cst_pkg::*;

    typedef enum int {
        SC_IDLE, SC_NUM, SC_NAME, SC_SLASH, SC_LINE, SC_BLOCK, SC_STAR
    } scan_t;

    scan_t       scan;
    logic [31:0] num_acc;
    logic [7:0]  word [MaxIdLen];
    int          word_len;
    logic        word_cut;
    logic [7:0]  names [TableEntries][MaxIdLen];
    int          name_len [TableEntries];
    int          name_cnt;
    logic [15:0] lines;
    out_item_t   token_q [$];
    out_item_t   tok_buf [$];

    assign pending_tokens = token_q.size();

    function automatic logic space_ch(logic [7:0] c);
        return c == 8'd32 || (c >= 8'd9 && c <= 8'd13);
    endfunction
    function automatic logic digit_ch(logic [7:0] c);
        return c >= 8'd48 && c <= 8'd57;
    endfunction
    function automatic logic letter_ch(logic [7:0] c);
        return (c >= 8'd65 && c <= 8'd90) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    task automatic emit(logic [2:0] kind, logic [31:0] num, logic [5:0] idx,
                        logic nw, logic [7:0] op, logic cut, logic full);
        out_item_t t;
        t = '0;
        t.kind = kind;
        t.number_value = num;
        t.entry_index = idx;
        t.is_new = nw;
        t.op_char = op;
        t.name_truncated = cut;
        t.table_full = full;
        t.line_number = lines;
        tok_buf.push_back(t);
    endtask

    task automatic next_line();
        if (lines != 16'hFFFF)
            lines++;
    endtask

    task automatic lookup_word();
        logic hit;
        for (int i = 0; i < name_cnt; i++)
        begin
            hit = (name_len[i] == word_len);
            for (int j = 0; j < word_len; j++)
                if (names[i][j] != word[j])
                    hit = 0;
            if (hit)
            begin
                emit(i == 0 ? KIND_TRUE : i == 1 ? KIND_FALSE : KIND_IDENT,
                     0, i[5:0], 0, 0, word_cut, 0);
                return;
            end
        end
        if (name_cnt < TableEntries)
        begin
            for (int j = 0; j < word_len; j++)
                names[name_cnt][j] = word[j];
            name_len[name_cnt] = word_len;
            emit(KIND_IDENT, 0, name_cnt[5:0], 1, 0, word_cut, 0);
            name_cnt++;
        end
        else
            emit(KIND_IDENT, 0, 0, 0, 0, word_cut, 1);
    endtask

    task automatic start_token(logic [7:0] c);
        scan = SC_IDLE;
        if (space_ch(c))
        begin
            if (c == CH_NL)
                next_line();
        end
        else if (digit_ch(c))
        begin
            num_acc = 32'(c - CH_ZERO);
            scan = SC_NUM;
        end
        else if (c == CH_SLASH)
            scan = SC_SLASH;
        else if (letter_ch(c))
        begin
            word[0] = c;
            word_len = 1;
            word_cut = 0;
            scan = SC_NAME;
        end
        else
            emit(KIND_OP, 0, 0, 0, c, 0, 0);
    endtask

    task automatic scan_char(in_item_t it);
        logic [7:0] c;
        c = it.ch;
        tok_buf.delete();
        if (it.end_of_input)
        begin
            if (scan == SC_NUM)
                emit(KIND_NUMBER, num_acc, 0, 0, 0, 0, 0);
            else if (scan == SC_NAME)
                lookup_word();
            else if (scan == SC_SLASH)
                emit(KIND_OP, 0, 0, 0, CH_SLASH, 0, 0);
            scan = SC_IDLE;
            num_acc = 0;
            word_len = 0;
            word_cut = 0;
        end
        else
            case (scan)
                SC_NUM:
                    if (digit_ch(c))
                        num_acc = num_acc * 10 + 32'(c - CH_ZERO);
                    else
                    begin
                        emit(KIND_NUMBER, num_acc, 0, 0, 0, 0, 0);
                        start_token(c);
                    end
                SC_NAME:
                    if (letter_ch(c))
                    begin
                        if (word_len < MaxIdLen)
                            word[word_len++] = c;
                        else
                            word_cut = 1;
                    end
                    else
                    begin
                        lookup_word();
                        start_token(c);
                    end
                SC_SLASH:
                    if (c == CH_SLASH)
                        scan = SC_LINE;
                    else if (c == CH_STAR)
                        scan = SC_BLOCK;
                    else
                    begin
                        emit(KIND_OP, 0, 0, 0, CH_SLASH, 0, 0);
                        start_token(c);
                    end
                SC_LINE:
                    if (c == CH_NL)
                    begin
                        next_line();
                        scan = SC_IDLE;
                    end
                SC_BLOCK:
                    if (c == CH_NL)
                        next_line();
                    else if (c == CH_STAR)
                        scan = SC_STAR;
                SC_STAR:
                    if (c == CH_SLASH)
                        scan = SC_IDLE;
                    else if (c != CH_STAR)
                    begin
                        if (c == CH_NL)
                            next_line();
                        scan = SC_BLOCK;
                    end
                default:
                    start_token(c);
            endcase
        if (tok_buf.size() > 0)
            tok_buf[$].last = 1;
        foreach (tok_buf[i])
            token_q.push_back(tok_buf[i]);
    endtask

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch %s: got %0h expected %0h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic compare_token(out_item_t g);
        out_item_t e;
        if (token_q.size() == 0)
        begin
            report("unexpected token", 32'(g.kind), 0);
            return;
        end
        e = token_q.pop_front();
        if (g.kind != e.kind) report("kind", 32'(g.kind), 32'(e.kind));
        if (g.number_value != e.number_value)
            report("number_value", g.number_value, e.number_value);
        if (g.entry_index != e.entry_index)
            report("entry_index", 32'(g.entry_index), 32'(e.entry_index));
        if (g.is_new != e.is_new) report("is_new", 32'(g.is_new), 32'(e.is_new));
        if (g.op_char != e.op_char) report("op_char", 32'(g.op_char), 32'(e.op_char));
        if (g.name_truncated != e.name_truncated)
            report("name_truncated", 32'(g.name_truncated), 32'(e.name_truncated));
        if (g.table_full != e.table_full)
            report("table_full", 32'(g.table_full), 32'(e.table_full));
        if (g.line_number != e.line_number)
            report("line_number", 32'(g.line_number), 32'(e.line_number));
        if (g.last != e.last) report("last", 32'(g.last), 32'(e.last));
    endtask

    initial
    begin
        fail_count = 0;
        scan = SC_IDLE;
        num_acc = 0;
        word_len = 0;
        word_cut = 0;
        for (int i = 0; i < TableEntries; i++)
            name_len[i] = 0;
        names[0][0] = "t"; names[0][1] = "r"; names[0][2] = "u"; names[0][3] = "e";
        names[1][0] = "f"; names[1][1] = "a"; names[1][2] = "l"; names[1][3] = "s";
        names[1][4] = "e";
        name_len[0] = 4;
        name_len[1] = 5;
        name_cnt = 2;
        lines = 1;
    end

    always @(posedge clk)
        if (rst_n)
        begin
            if (out_valid && out_ready)
                compare_token(out_data);
            if (in_valid && in_ready)
                scan_char(in_data);
        end
endmodule

// ===== tb/sv/tb.sv =====
// Top of the tokenizer testbench: clock, reset, character stimulus, verdict.
// Depends on cst_pkg, char_stream_tokenizer and tb_token_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cst_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_data;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_data;
    int        fail_count;
    int        pending_tokens;
    int        stall_mode;
    int        burst_left;
    string     text_q [$];

    char_stream_tokenizer dut (.*);

    tb_token_checker checker_i (
        .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
        .out_data, .fail_count, .pending_tokens
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // receiver stall pattern, changes mode now and then
    always @(posedge clk)
    begin
        if ($urandom_range(0, 63) == 0)
            stall_mode <= $urandom_range(0, 3);
        case (stall_mode)
            0: out_ready <= 1'b1;
            1: out_ready <= $urandom_range(0, 3) != 0;
            2: out_ready <= $urandom_range(0, 1);
            default: out_ready <= $urandom_range(0, 7) == 0;
        endcase
    end

    // valid drops only during a gap between bursts
    task automatic send(logic [7:0] c, logic eoi);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 1) ? $urandom_range(1, 6) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data.ch <= c;
        in_data.end_of_input <= eoi;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send(s[i], 0);
    endtask

    function automatic string rand_word(int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'($urandom_range(0, 1) ? 8'($urandom_range(65, 90))
                                                 : 8'($urandom_range(97, 122)))};
        return s;
    endfunction

    function automatic string rand_piece();
        string s;
        int len;
        case ($urandom_range(0, 11))
            0, 1: s = rand_word($urandom_range(1, 4));
            2: s = rand_word($urandom_range(15, 20));
            3: s = $urandom_range(0, 1) ? "true" : "false";
            4, 5:
            begin
                len = $urandom_range(1, 11);
                s = "";
                for (int i = 0; i < len; i++)
                    s = {s, string'(8'($urandom_range(48, 57)))};
            end
            6: s = "//c\n";
            7: s = $urandom_range(0, 1) ? "/*x**\n*/" : "/*\n*y*/";
            8: s = "/";
            9: s = string'(8'($urandom_range(0, 255)));
            10: s = $urandom_range(0, 1) ? " " : "\n";
            default: s = string'(8'($urandom_range(33, 126)));
        endcase
        return s;
    endfunction

    initial
    begin
        int sent;
        int waited;
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        out_ready = 0;
        stall_mode = 0;
        burst_left = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        send_text("true false abc abc 4294967295 4294967296 0 ");
        send_text("abcdefghijklmnopqrstuvwxyzAB abcdefghijklmnopqrstuvwxyzCD ");
        send_text("a/b // note */\n/* x ** \n */ /**/ +\t\r\v\f");
        send(8'd0, 0);
        send(8'd255, 0);
        send("7", 0);
        send(8'hAA, 1);
        send("/", 0);
        send(8'h55, 1);
        send_text("/* open");
        send(8'd0, 1);
        send_text("xyz");
        send(8'd0, 1);

        sent = 0;
        while (sent < 700)
        begin
            string p;
            p = rand_piece();
            send_text(p);
            sent += p.len();
            if ($urandom_range(0, 40) == 0)
            begin
                send(8'($urandom_range(0, 255)), 1);
                sent++;
            end
        end
        // fill the table to capacity
        for (int i = 0; i < 40; i++)
            send_text({"Q", rand_word(6), " "});
        send_text("trueX zz ");
        send(8'd0, 1);
        in_valid <= 1'b0;

        waited = 0;
        while (pending_tokens != 0 && waited < 100000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (2000) @(posedge clk);
        if (fail_count == 0 && pending_tokens == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb NOT OK");
        $finish;
    end
endmodule
